@@ src/pal_pkg.sv @@
// Shared types, field widths and codes for the positional array list.
`default_nettype none
package pal_pkg;

	localparam int PAL_DEPTH       = 64;
	localparam int PAL_ENTRY_WIDTH = 32;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_REM_POS   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  entry_value;
	} pal_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  removed_value;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} pal_rsp_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} pal_cmd_t;

endpackage
`default_nettype wire

@@ src/pal_cell.sv @@
// List cell: one entry, loaded or shifted up or down by the broadcast command.
`default_nettype none
module pal_cell
	import pal_pkg::*;
#(
	parameter int DEPTH       = PAL_DEPTH,
	parameter int ENTRY_WIDTH = PAL_ENTRY_WIDTH,
	parameter int IDX         = 0
) (
	input  wire                                            clk,
	input  pal_cmd_t                                       cmd,
	input  wire  [(($clog2(DEPTH+1) > POS_W) ? $clog2(DEPTH+1) : POS_W)-1:0] at,
	input  wire  [ENTRY_WIDTH-1:0]                         ins_value,
	input  wire  [ENTRY_WIDTH-1:0]                         left_data,
	input  wire  [ENTRY_WIDTH-1:0]                         right_data,
	output logic [ENTRY_WIDTH-1:0]                         data,
	output logic [ENTRY_WIDTH-1:0]                         taken
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

	logic [ENTRY_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (cmd.ins && (MY_IDX > at)) begin
			data_q <= left_data;
		end else if (cmd.ins && (MY_IDX == at)) begin
			data_q <= ins_value;
		end else if (cmd.rem && (MY_IDX >= at)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data  = data_q;
	assign taken = (cmd.rem && (MY_IDX == at)) ? data_q : '0;

endmodule
`default_nettype wire

@@ src/pal_ctrl.sv @@
// List control: occupancy, capacity register, request checks and cell command.
`default_nettype none
module pal_ctrl
	import pal_pkg::*;
#(
	parameter int DEPTH = PAL_DEPTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr,
	input  wire  [CAP_W-1:0]            cfg_data,
	input  wire                         fire,
	input  wire  [ACTION_W-1:0]         action,
	input  wire  [POS_W-1:0]            position,
	output pal_cmd_t                    cmd,
	output logic [(($clog2(DEPTH+1) > POS_W) ? $clog2(DEPTH+1) : POS_W)-1:0] at,
	output logic [$clog2(DEPTH+1)-1:0]  count_next,
	output logic [STATUS_W-1:0]         status
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [AT_W-1:0] DEPTH_W = AT_W'(DEPTH);

	logic [CNT_W-1:0] occ_q;
	logic [CAP_W-1:0] cap_q;
	logic [AT_W-1:0]  occ_w;
	logic [AT_W-1:0]  cap_w;
	logic [AT_W-1:0]  eff_cap;
	logic             full;
	pal_cmd_t         req_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		occ_w   = AT_W'(occ_q);
		cap_w   = AT_W'(cap_q);
		eff_cap = (cap_w < DEPTH_W) ? cap_w : DEPTH_W;
		full    = (occ_w >= eff_cap);
		req_cmd = '0;
		at      = '0;
		status  = ST_OK;
		unique case (action)
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
				if (action == ACT_INS_BACK) begin
					at = occ_w;
				end else if (action == ACT_INS_POS) begin
					at = AT_W'(position);
				end
				priority if (full) begin
					status = ST_FULL;
				end else if (at > occ_w) begin
					status = ST_RANGE;
				end else begin
					req_cmd.ins = 1'b1;
				end
			end
			ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_POS: begin
				if (action == ACT_REM_BACK && occ_w != '0) begin
					at = occ_w - AT_W'(1);
				end else if (action == ACT_REM_POS) begin
					at = AT_W'(position);
				end
				priority if (occ_w == '0) begin
					status = ST_EMPTY;
				end else if (at >= occ_w) begin
					status = ST_RANGE;
				end else begin
					req_cmd.rem = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
		cmd        = fire ? req_cmd : '0;
		count_next = occ_q + CNT_W'(req_cmd.ins) - CNT_W'(req_cmd.rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (fire) begin
			occ_q <= count_next;
		end
	end

endmodule
`default_nettype wire

@@ src/positional_array_list_unit.sv @@
// Top level of the positional array list: cell row, control and result register.
// A request's result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle; the cell row shifts on the accepting edge
// and the result register is the only stage, so a stalled result holds requests.
// Reset clears occupancy, the result valid and sets capacity to 64; entries are
// not cleared and only entries below the occupancy are ever read.
`default_nettype none
module positional_array_list_unit
	import pal_pkg::*;
#(
	parameter int DEPTH       = PAL_DEPTH,
	parameter int ENTRY_WIDTH = PAL_ENTRY_WIDTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  pal_req_t         req,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output pal_rsp_t         rsp,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [CAP_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic                   fire;
	logic                   rsp_valid_q;
	pal_rsp_t               rsp_q;
	pal_cmd_t               cmd;
	logic [AT_W-1:0]        at;
	logic [CNT_W-1:0]       count_next;
	logic [STATUS_W-1:0]    status;
	logic [ENTRY_WIDTH-1:0] ins_value;
	logic [ENTRY_WIDTH-1:0] cell_data  [DEPTH];
	logic [ENTRY_WIDTH-1:0] cell_taken [DEPTH];
	logic [ENTRY_WIDTH-1:0] taken;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign ins_value = ENTRY_WIDTH'(req.entry_value);

	pal_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.action    (req.action),
		.position  (req.position),
		.cmd       (cmd),
		.at        (at),
		.count_next(count_next),
		.status    (status)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_data;
		logic [ENTRY_WIDTH-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = cell_data[i+1];
		end

		pal_cell #(
			.DEPTH      (DEPTH),
			.ENTRY_WIDTH(ENTRY_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.at        (at),
			.ins_value (ins_value),
			.left_data (left_data),
			.right_data(right_data),
			.data      (cell_data[i]),
			.taken     (cell_taken[i])
		);
	end

	always_comb begin
		taken = '0;
		for (int i = 0; i < DEPTH; i++) begin
			taken = taken | cell_taken[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= fire || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.removed_value <= VALUE_W'(taken);
			rsp_q.entry_count   <= COUNT_W'(count_next);
			rsp_q.status        <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
